### sv/dlvc_pkg.sv
// Shared types and constants for the debounced latching valve controller.
package dlvc_pkg;

	// Register map, word index (byte address bits [4:2])
	typedef enum logic [2:0] {
		REG_VALVE_PULSE     = 3'd0,
		REG_SENSOR_DEBOUNCE = 3'd1,
		REG_SENSOR_ON_LEVEL = 3'd2,
		REG_HB_PERIOD       = 3'd3,
		REG_HB_ON           = 3'd4
	} reg_idx_t;

	localparam int unsigned CFG_W  = 16;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [CFG_W-1:0] RST_VALVE_PULSE     = 16'd50;
	localparam logic [CFG_W-1:0] RST_SENSOR_DEBOUNCE = 16'd50;
	localparam logic             RST_SENSOR_ON_LEVEL = 1'b1;
	localparam logic [CFG_W-1:0] RST_HB_PERIOD       = 16'd1000;
	localparam logic [CFG_W-1:0] RST_HB_ON           = 16'd200;

	// Coil register bit positions
	localparam int unsigned COIL_ON_BIT  = 0;
	localparam int unsigned COIL_OFF_BIT = 1;
	localparam int unsigned POWER_BIT    = 2;

	typedef struct packed {
		logic [CFG_W-1:0] valve_pulse_ms;
		logic [CFG_W-1:0] sensor_debounce_ms;
		logic             sensor_on_level;
		logic [CFG_W-1:0] heartbeat_period_ms;
		logic [CFG_W-1:0] heartbeat_on_ms;
	} cfg_t;

	typedef struct packed {
		logic sensor_stable;
		logic heartbeat_led;
		logic pulse_busy;
		logic valve_open_state;
		logic power_enable;
		logic coil_off_drive;
		logic coil_on_drive;
	} result_t;

endpackage

### sv/dlvc_tick.sv
// Per-tick state update: coil pulse timer, heartbeat timer and sensor debounce.
module dlvc_tick #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             sensor_level,
	input  dlvc_pkg::cfg_t    cfg,
	output dlvc_pkg::result_t res
);
	import dlvc_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam int PH_W  = (COUNT_WIDTH + 1 > CFG_W) ? COUNT_WIDTH + 1 : CFG_W;

	logic                   start_pending_q, start_pending_d;
	logic                   pulse_active_q, pulse_active_d;
	logic                   want_open_q, want_open_d;
	logic                   want_close_q, want_close_d;
	logic                   valve_state_q, valve_state_d;
	logic [COUNT_WIDTH-1:0] pulse_count_q, pulse_count_d;
	logic [2:0]             coil_q, coil_d;
	logic [COUNT_WIDTH-1:0] tick_phase_q, tick_phase_d;
	logic                   beat_active_q, beat_active_d;
	logic [COUNT_WIDTH-1:0] beat_count_q, beat_count_d;
	logic                   last_level_q;
	logic [COUNT_WIDTH-1:0] stable_count_q, stable_count_d;
	logic [PH_W-1:0]        phase_next;
	logic                   pulse_done, beat_done, stable;

	always_comb begin
		start_pending_d = start_pending_q;
		pulse_active_d  = pulse_active_q;
		want_open_d     = want_open_q;
		want_close_d    = want_close_q;
		valve_state_d   = valve_state_q;
		pulse_count_d   = pulse_count_q;
		coil_d          = coil_q;
		beat_active_d   = beat_active_q;
		beat_count_d    = beat_count_q;
		pulse_done      = 1'b0;
		beat_done       = 1'b0;

		// coil pulse
		if (start_pending_d) begin
			if (want_open_d) begin
				coil_d = 3'b000;
				coil_d[POWER_BIT] = 1'b1;
				coil_d[COIL_ON_BIT] = 1'b1;
				valve_state_d = 1'b1;
			end else if (want_close_d) begin
				coil_d = 3'b000;
				coil_d[POWER_BIT] = 1'b1;
				coil_d[COIL_OFF_BIT] = 1'b1;
				valve_state_d = 1'b0;
			end
			pulse_count_d   = '0;
			start_pending_d = 1'b0;
			pulse_active_d  = 1'b1;
		end
		if (pulse_active_d) begin
			pulse_done = CMP_W'(pulse_count_d) >= CMP_W'(cfg.valve_pulse_ms);
			pulse_count_d = (&pulse_count_d) ? pulse_count_d : pulse_count_d + 1'b1;
			if (pulse_done) begin
				if (want_open_d) begin
					coil_d[COIL_ON_BIT] = 1'b0;
					coil_d[POWER_BIT] = 1'b0;
					want_open_d = 1'b0;
				end else if (want_close_d) begin
					coil_d[COIL_OFF_BIT] = 1'b0;
					coil_d[POWER_BIT] = 1'b0;
					want_close_d = 1'b0;
				end
				pulse_active_d = 1'b0;
			end
		end

		// heartbeat; phase compare is done at least one bit wider than the counter
		phase_next = PH_W'(tick_phase_q) + 1'b1;
		if (phase_next >= PH_W'(cfg.heartbeat_period_ms)) begin
			phase_next = '0;
			beat_active_d = 1'b1;
		end
		tick_phase_d = phase_next[COUNT_WIDTH-1:0];
		if (beat_active_d) begin
			beat_done = CMP_W'(beat_count_d) >= CMP_W'(cfg.heartbeat_on_ms);
			beat_count_d = (&beat_count_d) ? beat_count_d : beat_count_d + 1'b1;
			if (beat_done) begin
				beat_active_d = 1'b0;
				beat_count_d  = '0;
			end
		end

		// sensor debounce
		if (sensor_level != last_level_q)
			stable_count_d = '0;
		else
			stable_count_d = (&stable_count_q) ? stable_count_q : stable_count_q + 1'b1;
		stable = CMP_W'(stable_count_d) > CMP_W'(cfg.sensor_debounce_ms);
		if (stable) begin
			if (sensor_level == cfg.sensor_on_level && !valve_state_d) begin
				want_open_d     = 1'b1;
				want_close_d    = 1'b0;
				pulse_active_d  = 1'b0;
				start_pending_d = 1'b1;
			end else if (sensor_level != cfg.sensor_on_level && valve_state_d) begin
				want_open_d     = 1'b0;
				want_close_d    = 1'b1;
				pulse_active_d  = 1'b0;
				start_pending_d = 1'b1;
			end
		end

		res.coil_on_drive    = coil_d[COIL_ON_BIT];
		res.coil_off_drive   = coil_d[COIL_OFF_BIT];
		res.power_enable     = coil_d[POWER_BIT];
		res.valve_open_state = valve_state_d;
		res.pulse_busy       = start_pending_d | pulse_active_d;
		res.heartbeat_led    = beat_active_d;
		res.sensor_stable    = stable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pending_q <= 1'b1;
			pulse_active_q  <= 1'b0;
			want_open_q     <= 1'b0;
			want_close_q    <= 1'b1;
			valve_state_q   <= 1'b0;
			pulse_count_q   <= '0;
			coil_q          <= '0;
			tick_phase_q    <= '0;
			beat_active_q   <= 1'b0;
			beat_count_q    <= '0;
			last_level_q    <= RST_SENSOR_ON_LEVEL;
			stable_count_q  <= '0;
		end else if (step) begin
			start_pending_q <= start_pending_d;
			pulse_active_q  <= pulse_active_d;
			want_open_q     <= want_open_d;
			want_close_q    <= want_close_d;
			valve_state_q   <= valve_state_d;
			pulse_count_q   <= pulse_count_d;
			coil_q          <= coil_d;
			tick_phase_q    <= tick_phase_d;
			beat_active_q   <= beat_active_d;
			beat_count_q    <= beat_count_d;
			last_level_q    <= sensor_level;
			stable_count_q  <= stable_count_d;
		end
	end

`ifndef SYNTHESIS
	a_coils_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(coil_q[COIL_ON_BIT] && coil_q[COIL_OFF_BIT]))
		else $error("both coils driven");
	a_power_matches_coil: assert property (@(posedge clk) disable iff (!arst_n)
		coil_q[POWER_BIT] == (coil_q[COIL_ON_BIT] | coil_q[COIL_OFF_BIT]))
		else $error("coil power out of step with coil drive");
	a_want_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(want_open_q && want_close_q))
		else $error("open and close requested together");
	a_pending_not_active: assert property (@(posedge clk) disable iff (!arst_n)
		start_pending_q |-> !pulse_active_q)
		else $error("pulse running while a new one is pending");
	a_beat_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_count_q != '0) |-> beat_active_q)
		else $error("heartbeat count left over while LED is off");
`endif

endmodule

### sv/debounced_latching_valve_control_top.sv
// Top level: tick stream in, per-tick valve/heartbeat status out, APB register port.
// One result transfer comes out for every input transfer (one 1 ms tick each).
// A tick goes through an input register and then the state update into the
// result register, which presents its result. A tick leaves the input
// register whenever the result register is empty or draining, so a new tick
// is taken every cycle as long as the result side keeps up; a stalled result
// side holds both registers. The state update is a handful of counter
// compares and flag updates done combinationally. Registers at byte addresses
// 0x00 valve pulse, 0x04 sensor debounce, 0x08 sensor on-level, 0x0C heartbeat
// period, 0x10 heartbeat on time; write them only while no tick is in flight.
module debounced_latching_valve_control_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [0] sensor_level, [7:1] zero
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] coil_on_drive, [1] coil_off_drive, [2] power_enable, [3] valve_open_state,
	// [4] pulse_busy, [5] heartbeat_led, [6] sensor_stable, [7] zero
	output logic [7:0]                     m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dlvc_pkg::ADDR_W-1:0]    paddr,
	input  logic [dlvc_pkg::DATA_W-1:0]    pwdata,
	output logic [dlvc_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import dlvc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     valid_s1, level_s1;
	logic     out_valid_q;
	result_t  res, res_q;
	logic     advance;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.valve_pulse_ms      <= RST_VALVE_PULSE;
			cfg_q.sensor_debounce_ms  <= RST_SENSOR_DEBOUNCE;
			cfg_q.sensor_on_level     <= RST_SENSOR_ON_LEVEL;
			cfg_q.heartbeat_period_ms <= RST_HB_PERIOD;
			cfg_q.heartbeat_on_ms     <= RST_HB_ON;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_VALVE_PULSE:     cfg_q.valve_pulse_ms      <= pwdata[CFG_W-1:0];
				REG_SENSOR_DEBOUNCE: cfg_q.sensor_debounce_ms  <= pwdata[CFG_W-1:0];
				REG_SENSOR_ON_LEVEL: cfg_q.sensor_on_level     <= pwdata[0];
				REG_HB_PERIOD:       cfg_q.heartbeat_period_ms <= pwdata[CFG_W-1:0];
				REG_HB_ON:           cfg_q.heartbeat_on_ms     <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_VALVE_PULSE:     prdata = DATA_W'(cfg_q.valve_pulse_ms);
			REG_SENSOR_DEBOUNCE: prdata = DATA_W'(cfg_q.sensor_debounce_ms);
			REG_SENSOR_ON_LEVEL: prdata = DATA_W'(cfg_q.sensor_on_level);
			REG_HB_PERIOD:       prdata = DATA_W'(cfg_q.heartbeat_period_ms);
			REG_HB_ON:           prdata = DATA_W'(cfg_q.heartbeat_on_ms);
			default:             prdata = '0;
		endcase
	end

	// stage 1 moves into the result register when that register is free or draining
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			level_s1 <= s_tdata[0];
		if (advance)
			res_q <= res;
	end

	dlvc_tick #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_tick (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.sensor_level (level_s1),
		.cfg          (cfg_q),
		.res          (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.sensor_stable, res_q.heartbeat_led, res_q.pulse_busy,
		res_q.valve_open_state, res_q.power_enable, res_q.coil_off_drive,
		res_q.coil_on_drive};

endmodule

### verif/valve_status_checker.sv
`timescale 1ns / 100ps
// Checker: tracks register writes and ticks, predicts each status result and compares it.
module valve_status_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [0] sensor_level, [7:1] zero
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] coil_on_drive, [1] coil_off_drive, [2] power_enable, [3] valve_open_state,
	// [4] pulse_busy, [5] heartbeat_led, [6] sensor_stable, [7] zero
	input  logic [7:0]                  m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dlvc_pkg::ADDR_W-1:0] paddr,
	input  logic [dlvc_pkg::DATA_W-1:0] pwdata,
	input  logic                        pready,
	output int                          fail_count,
	output int                          outstanding
);
	import dlvc_pkg::*;

	localparam logic [CFG_W-1:0] CNT_MAX = '1;

	cfg_t             cfg;
	logic             start_pending, pulse_active, want_open, want_close, valve_state;
	logic             beat_active, last_level;
	logic [CFG_W-1:0] pulse_count, tick_phase, beat_count, stable_count;
	logic [2:0]       coils;
	result_t          expected_status_q[$];
	int               result_idx;

	function automatic logic [CFG_W-1:0] sat_inc(input logic [CFG_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	task automatic request_move(input logic open);
		want_open = open;
		want_close = !open;
		pulse_active = 1'b0;
		start_pending = 1'b1;
	endtask

	// One 1 ms tick: coil timer, heartbeat, then sensor debounce.
	task automatic valve_tick(input logic lvl, output result_t r);
		logic             done;
		logic             stable;
		logic [CFG_W:0]   next_phase;
		stable = 1'b0;
		if (start_pending) begin
			if (want_open) begin
				coils = '0;
				coils[POWER_BIT] = 1'b1;
				coils[COIL_ON_BIT] = 1'b1;
				valve_state = 1'b1;
			end else if (want_close) begin
				coils = '0;
				coils[POWER_BIT] = 1'b1;
				coils[COIL_OFF_BIT] = 1'b1;
				valve_state = 1'b0;
			end
			pulse_count = '0;
			start_pending = 1'b0;
			pulse_active = 1'b1;
		end
		if (pulse_active) begin
			done = (pulse_count >= cfg.valve_pulse_ms);
			pulse_count = sat_inc(pulse_count);
			if (done) begin
				if (want_open) begin
					coils[COIL_ON_BIT] = 1'b0;
					coils[POWER_BIT] = 1'b0;
					want_open = 1'b0;
				end else if (want_close) begin
					coils[COIL_OFF_BIT] = 1'b0;
					coils[POWER_BIT] = 1'b0;
					want_close = 1'b0;
				end
				pulse_active = 1'b0;
			end
		end

		next_phase = {1'b0, tick_phase} + 1'b1;
		if (next_phase >= {1'b0, cfg.heartbeat_period_ms}) begin
			next_phase = '0;
			beat_active = 1'b1;
		end
		tick_phase = next_phase[CFG_W-1:0];
		if (beat_active) begin
			done = (beat_count >= cfg.heartbeat_on_ms);
			beat_count = sat_inc(beat_count);
			if (done) begin
				beat_active = 1'b0;
				beat_count = '0;
			end
		end

		if (lvl != last_level)
			stable_count = '0;
		else
			stable_count = sat_inc(stable_count);
		if (stable_count > cfg.sensor_debounce_ms) begin
			stable = 1'b1;
			if (lvl == cfg.sensor_on_level && !valve_state)
				request_move(1'b1);
			else if (lvl != cfg.sensor_on_level && valve_state)
				request_move(1'b0);
		end
		last_level = lvl;

		r.coil_on_drive    = coils[COIL_ON_BIT];
		r.coil_off_drive   = coils[COIL_OFF_BIT];
		r.power_enable     = coils[POWER_BIT];
		r.valve_open_state = valve_state;
		r.pulse_busy       = start_pending || pulse_active;
		r.heartbeat_led    = beat_active;
		r.sensor_stable    = stable;
	endtask

	task automatic check_bit(input string field, input logic exp, input logic act);
		if (act !== exp) begin
			if (fail_count < 10)
				$display("mismatch in result %0d: %s expected %b got %b",
					result_idx, field, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			cfg.valve_pulse_ms      = RST_VALVE_PULSE;
			cfg.sensor_debounce_ms  = RST_SENSOR_DEBOUNCE;
			cfg.sensor_on_level     = RST_SENSOR_ON_LEVEL;
			cfg.heartbeat_period_ms = RST_HB_PERIOD;
			cfg.heartbeat_on_ms     = RST_HB_ON;
			start_pending = 1'b1;
			pulse_active  = 1'b0;
			want_open     = 1'b0;
			want_close    = 1'b1;
			valve_state   = 1'b0;
			pulse_count   = '0;
			coils         = '0;
			tick_phase    = '0;
			beat_active   = 1'b0;
			beat_count    = '0;
			last_level    = RST_SENSOR_ON_LEVEL;
			stable_count  = '0;
			expected_status_q.delete();
			result_idx  = 0;
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_VALVE_PULSE:     cfg.valve_pulse_ms = pwdata[CFG_W-1:0];
					REG_SENSOR_DEBOUNCE: cfg.sensor_debounce_ms = pwdata[CFG_W-1:0];
					REG_SENSOR_ON_LEVEL: cfg.sensor_on_level = pwdata[0];
					REG_HB_PERIOD:       cfg.heartbeat_period_ms = pwdata[CFG_W-1:0];
					REG_HB_ON:           cfg.heartbeat_on_ms = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			// a result leaves only after the input and result registers, so pop before pushing
			if (m_tvalid && m_tready) begin
				if (expected_status_q.size() == 0) begin
					if (fail_count < 10)
						$display("status transfer %0d with no tick pending: got %b",
							result_idx, m_tdata);
					fail_count++;
				end else begin
					want = expected_status_q.pop_front();
					got = result_t'(m_tdata[6:0]);
					check_bit("coil_on_drive", want.coil_on_drive, got.coil_on_drive);
					check_bit("coil_off_drive", want.coil_off_drive, got.coil_off_drive);
					check_bit("power_enable", want.power_enable, got.power_enable);
					check_bit("valve_open_state", want.valve_open_state,
						got.valve_open_state);
					check_bit("pulse_busy", want.pulse_busy, got.pulse_busy);
					check_bit("heartbeat_led", want.heartbeat_led, got.heartbeat_led);
					check_bit("sensor_stable", want.sensor_stable, got.sensor_stable);
					check_bit("pad bit", 1'b0, m_tdata[7]);
				end
				result_idx++;
			end
			if (s_tvalid && s_tready) begin
				valve_tick(s_tdata[0], want);
				expected_status_q.push_back(want);
			end
			outstanding = expected_status_q.size();
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives sensor ticks and register writes into the valve controller.
module testbench;
	import dlvc_pkg::*;

	localparam int WATCHDOG_LIMIT = 200;

	logic              clk, arst_n;
	logic              s_tvalid, s_tready, m_tvalid, m_tready;
	logic [7:0]        s_tdata;   // [0] sensor_level, [7:1] zero
	// [0] coil_on_drive, [1] coil_off_drive, [2] power_enable, [3] valve_open_state,
	// [4] pulse_busy, [5] heartbeat_led, [6] sensor_stable, [7] zero
	logic [7:0]        m_tdata;
	logic              psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	int                fail_count, outstanding, quiet_cycles, ticks_sent, stall_len;
	logic              idle_en;
	logic [CFG_W-1:0]  cur_pulse, cur_debounce;

	debounced_latching_valve_control_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	valve_status_checker status_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog: cycles with no transfer on any port
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side back-pressure
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_en && m_tready && $urandom_range(0, 5) == 0) begin
				stall_len = $urandom_range(1, 4);
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	function automatic logic [CFG_W-1:0] pick_count(input int common_max);
		case ($urandom_range(0, 11))
			0: return '1;
			1: return CFG_W'($urandom);
			2: return '0;
			default: return CFG_W'($urandom_range(0, common_max));
		endcase
	endfunction

	// back-to-back writes keep psel high; it drops after the last access
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] debounce,
			input logic on_level, input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] on_ms);
		cur_pulse = pulse;
		cur_debounce = debounce;
		write_reg(REG_VALVE_PULSE, pulse);
		write_reg(REG_SENSOR_DEBOUNCE, debounce);
		write_reg(REG_SENSOR_ON_LEVEL, CFG_W'(on_level));
		write_reg(REG_HB_PERIOD, period);
		write_reg(REG_HB_ON, on_ms);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_tick(input logic lvl);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, lvl};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		ticks_sent++;
	endtask

	task automatic send_pattern(input logic [15:0] levels, input int n);
		for (int i = 0; i < n; i++)
			send_tick(levels[i]);
	endtask

	// Mostly level runs long enough to debounce and outlast a pulse, some short glitches.
	task automatic run_phase(input int n);
		int   left;
		int   run_len;
		logic lvl;
		left = n;
		lvl = $urandom_range(0, 1);
		while (left > 0) begin
			if ($urandom_range(0, 9) < 7) begin
				if (cur_debounce < 16)
					run_len = $urandom_range(cur_debounce + 1,
						cur_debounce + 3 + ((cur_pulse < 8) ? cur_pulse : 8));
				else
					run_len = $urandom_range(1, 20);
			end else begin
				run_len = $urandom_range(1, 2);
			end
			if (run_len > left)
				run_len = left;
			repeat (run_len) send_tick(lvl);
			left -= run_len;
			lvl = ~lvl;
		end
	endtask

	// drain all results, then let the pipeline empty before touching registers
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		idle_en      = 1'b1;
		ticks_sent   = 0;
		cur_pulse    = RST_VALVE_PULSE;
		cur_debounce = RST_SENSOR_DEBOUNCE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: close pulse pending, last level equals on-level
		send_pattern(16'h000D, 4);
		settle();
		// zero pulse, zero debounce, zero period, zero on time, inverted on-level
		apply_config(16'd0, 16'd0, 1'b0, 16'd0, 16'd0);
		send_pattern(16'h000C, 5);
		settle();
		// short pulse so stable requests land mid-pulse; max period and on time
		apply_config(16'd2, 16'd1, 1'b1, 16'hFFFF, 16'hFFFF);
		send_pattern(16'h00C7, 9);
		settle();
		// period dropped below phase, LED retrigger, saturating debounce and pulse
		apply_config(16'hFFFF, 16'hFFFF, 1'b1, 16'd3, 16'd4);
		send_pattern(16'h0039, 7);
		settle();

		while (ticks_sent < 490) begin
			idle_en <= ($urandom_range(0, 3) != 0);
			apply_config(pick_count(6), pick_count(5), 1'($urandom_range(0, 1)),
				pick_count(12), pick_count(10));
			run_phase($urandom_range(25, 60));
			settle();
		end

		idle_en <= 1'b0;
		apply_config(16'd3, 16'd2, 1'b1, 16'd5, 16'd2);
		run_phase(40);
		settle();

		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

### sim.f
sv/dlvc_pkg.sv
sv/dlvc_tick.sv
sv/debounced_latching_valve_control_top.sv
verif/valve_status_checker.sv
verif/testbench.sv
